// ===== rtl/pcfl_pkg.sv =====
`timescale 1ns / 1ps
// Package for the per-CPU page free list allocator.
// Field widths, default sizes, status, operation and register codes.
package pcfl_pkg;

  localparam int ADDR_W     = 32;
  localparam int REQ_W      = 3;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam int CPU_COUNT_DEF  = 8;
  localparam int PAGE_SLOTS_DEF = 32768;
  localparam int PAGE_BYTES_DEF = 4096;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_OOM    = 2'd1,
    ST_REJECT = 2'd2
  } status_t;

  typedef enum logic {
    OP_FREE  = 1'b0,
    OP_ALLOC = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_BOUND  = 1'b0,
    REG_HIGH_BOUND = 1'b1
  } cfg_reg_t;

endpackage

// ===== rtl/pcfl_req_if.sv =====
`timescale 1ns / 1ps
// Request channel: valid/ready plus operation, requester and page address.
// Depends on pcfl_pkg for field widths.
interface pcfl_req_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [pcfl_pkg::REQ_W-1:0]  requester;
  logic [pcfl_pkg::ADDR_W-1:0] page_address;

  modport source (output valid, operation, requester, page_address, input ready);
  modport sink (input valid, operation, requester, page_address, output ready);
endinterface

// ===== rtl/pcfl_rsp_if.sv =====
`timescale 1ns / 1ps
// Response channel: valid/ready plus status and granted address.
// Depends on pcfl_pkg for field widths.
interface pcfl_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [pcfl_pkg::STATUS_W-1:0] status;
  logic [pcfl_pkg::ADDR_W-1:0]   granted_address;

  modport source (output valid, status, granted_address, input ready);
  modport sink (input valid, status, granted_address, output ready);
endinterface

// ===== rtl/pcfl_cfg_if.sv =====
`timescale 1ns / 1ps
// Configuration write channel: valid/ready plus register index and data.
// Depends on pcfl_pkg for field widths.
interface pcfl_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pcfl_pkg::CFG_IDX_W-1:0]  index;
  logic [pcfl_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/pcfl_cmp.sv =====
`timescale 1ns / 1ps
// Shared unsigned magnitude comparator used for both bound checks.
// Depends on pcfl_pkg for the address width.
module pcfl_cmp (
  input  logic [pcfl_pkg::ADDR_W-1:0] a,
  input  logic [pcfl_pkg::ADDR_W-1:0] b,
  output logic                        lt
);

  logic [pcfl_pkg::ADDR_W:0] diff;

  assign diff = {1'b0, a} - {1'b0, b};
  assign lt   = diff[pcfl_pkg::ADDR_W];

endmodule

// ===== rtl/pcfl_link_ram.sv =====
`timescale 1ns / 1ps
// Link table memory: one write port, one read port, registered read data.
// No dependencies; entries are undefined until written.
module pcfl_link_ram #(
  parameter int DEPTH  = 32768,
  parameter int DATA_W = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/per_cpu_page_free_list.sv =====
`timescale 1ns / 1ps
// Per-CPU page free list allocator with stealing: sequencer, list heads, config.
// Depends on pcfl_pkg, the channel interfaces, pcfl_cmp and pcfl_link_ram.
//
//   channel  | dir | handshake       | payload
//   ---------+-----+-----------------+-----------------------------------------
//   in_req   | in  | valid / ready   | operation, requester, page_address
//   out_rsp  | out | valid / ready   | status, granted_address
//   cfg_wr   | in  | valid / ready   | index, data (always ready)
//
// A free goes from acceptance through two compare passes (S_LOW, S_HIGH),
// writing the link table with the second, to S_DONE. An allocate does list
// select and link read, then pop and result; with every list empty it skips
// the pop. Ready returns as the output register loads, even while that
// result waits; a finished request holds in S_DONE while the register is full.
// Synchronous active-low reset empties all lists; no memory clearing pass.
module per_cpu_page_free_list #(
  parameter int CPU_COUNT  = pcfl_pkg::CPU_COUNT_DEF,
  parameter int PAGE_SLOTS = pcfl_pkg::PAGE_SLOTS_DEF,
  parameter int PAGE_BYTES = pcfl_pkg::PAGE_BYTES_DEF
) (
  input logic        clk,
  input logic        rst_n,
  pcfl_req_if.sink   in_req,
  pcfl_rsp_if.source out_rsp,
  pcfl_cfg_if.sink   cfg_wr
);

  localparam int AW = pcfl_pkg::ADDR_W;
  localparam int PW = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;
  localparam int CW = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
  localparam int SH = $clog2(PAGE_BYTES);
  localparam int LW = PW + 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOW  = 6'b000010,
    S_HIGH = 6'b000100,
    S_SEL  = 6'b001000,
    S_POP  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [pcfl_pkg::REQ_W-1:0]      req_r, req_nxt;
  logic [AW-1:0]                   addr_r, addr_nxt;
  logic [AW-1:0]                   low_r, low_nxt;
  logic [AW-1:0]                   high_r, high_nxt;
  logic                            lowfail_r, lowfail_nxt;
  logic [CW-1:0]                   sel_r, sel_nxt;
  logic [pcfl_pkg::STATUS_W-1:0]   res_status_r, res_status_nxt;
  logic [AW-1:0]                   res_addr_r, res_addr_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [pcfl_pkg::STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [AW-1:0]                   out_addr_r, out_addr_nxt;
  logic [PW-1:0]                   heads_r [CPU_COUNT];
  logic [PW-1:0]                   heads_nxt [CPU_COUNT];
  logic [CPU_COUNT-1:0]            hv_r, hv_nxt;

  logic                            cmp_lt;
  logic [AW-1:0]                   cmp_b;
  logic                            in_acc;
  logic                            out_free;
  logic [63:0]                     page64;
  logic [PW-1:0]                   page_idx;
  logic                            aligned;
  logic                            in_range;
  logic                            own_ok;
  logic [CW-1:0]                   own_idx;
  logic                            any_ne;
  logic [CW-1:0]                   low_idx;
  logic [CW-1:0]                   sel;
  logic                            free_ok;
  logic [63:0]                     grant64;

  logic                            ram_we;
  logic [PW-1:0]                   ram_waddr;
  logic [LW-1:0]                   ram_wdata;
  logic                            ram_re;
  logic [PW-1:0]                   ram_raddr;
  logic [LW-1:0]                   ram_rdata;

  pcfl_cmp u_cmp (
    .a  (addr_r),
    .b  (cmp_b),
    .lt (cmp_lt)
  );

  pcfl_link_ram #(
    .DEPTH  (PAGE_SLOTS),
    .DATA_W (LW)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_req.ready     = (state_r == S_IDLE);
  assign in_acc           = in_req.valid && in_req.ready;
  assign cfg_wr.ready     = 1'b1;
  assign out_rsp.valid    = out_valid_r;
  assign out_rsp.status   = out_status_r;
  assign out_rsp.granted_address = out_addr_r;
  assign out_free         = !out_valid_r || out_rsp.ready;

  assign cmp_b    = (state_r == S_LOW) ? low_r : high_r;
  assign page64   = 64'(addr_r >> SH);
  assign page_idx = page64[PW-1:0];
  assign aligned  = (addr_r[SH-1:0] == '0);
  assign in_range = (page64 < 64'(PAGE_SLOTS));
  assign own_ok   = ({{(AW-pcfl_pkg::REQ_W){1'b0}}, req_r} < AW'(CPU_COUNT));
  assign own_idx  = CW'(req_r);
  assign free_ok  = !lowfail_r && cmp_lt && aligned && in_range && own_ok;

  always_comb begin
    any_ne  = 1'b0;
    low_idx = '0;
    for (int i = CPU_COUNT - 1; i >= 0; i--) begin
      if (hv_r[i]) begin
        any_ne  = 1'b1;
        low_idx = CW'(i);
      end
    end
  end

  assign sel     = (own_ok && hv_r[own_idx]) ? own_idx : low_idx;
  assign grant64 = 64'(heads_r[sel_r]) << SH;

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    addr_nxt       = addr_r;
    low_nxt        = low_r;
    high_nxt       = high_r;
    lowfail_nxt    = lowfail_r;
    sel_nxt        = sel_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    heads_nxt      = heads_r;
    hv_nxt         = hv_r;
    ram_we         = 1'b0;
    ram_waddr      = page_idx;
    ram_wdata      = {hv_r[own_idx], heads_r[own_idx]};
    ram_re         = 1'b0;
    ram_raddr      = heads_r[sel];

    if (cfg_wr.valid && cfg_wr.ready) begin
      unique case (pcfl_pkg::cfg_reg_t'(cfg_wr.index))
        pcfl_pkg::REG_LOW_BOUND:  low_nxt  = cfg_wr.data;
        pcfl_pkg::REG_HIGH_BOUND: high_nxt = cfg_wr.data;
        default: ;
      endcase
    end

    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          req_nxt  = in_req.requester;
          addr_nxt = in_req.page_address;
          state_nxt = (in_req.operation == pcfl_pkg::OP_ALLOC) ? S_SEL : S_LOW;
        end
      end
      S_LOW: begin
        lowfail_nxt = cmp_lt;
        state_nxt   = S_HIGH;
      end
      S_HIGH: begin
        res_addr_nxt = '0;
        if (free_ok) begin
          ram_we             = 1'b1;
          heads_nxt[own_idx] = page_idx;
          hv_nxt[own_idx]    = 1'b1;
          res_status_nxt     = pcfl_pkg::ST_OK;
        end else begin
          res_status_nxt     = pcfl_pkg::ST_REJECT;
        end
        state_nxt = S_DONE;
      end
      S_SEL: begin
        if (any_ne) begin
          ram_re    = 1'b1;
          sel_nxt   = sel;
          state_nxt = S_POP;
        end else begin
          res_status_nxt = pcfl_pkg::ST_OOM;
          res_addr_nxt   = '0;
          state_nxt      = S_DONE;
        end
      end
      S_POP: begin
        heads_nxt[sel_r] = ram_rdata[PW-1:0];
        hv_nxt[sel_r]    = ram_rdata[PW];
        res_status_nxt   = pcfl_pkg::ST_OK;
        res_addr_nxt     = grant64[AW-1:0];
        state_nxt        = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_addr_nxt   = res_addr_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      hv_r        <= '0;
      low_r       <= '0;
      high_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      hv_r        <= hv_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    addr_r       <= addr_nxt;
    lowfail_r    <= lowfail_nxt;
    sel_r        <= sel_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    heads_r      <= heads_nxt;
  end

endmodule

// ===== rtl/pcfl_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the page free list allocator, bound to the top level.
// Depends on pcfl_pkg for status codes and field widths.
module pcfl_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [pcfl_pkg::STATUS_W-1:0] out_status,
  input logic [pcfl_pkg::ADDR_W-1:0]   out_granted
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pending_r, pending_nxt;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    pending_nxt = pending_r + 2'(in_acc) - 2'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_granted))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == pcfl_pkg::ST_OK) ||
                  ((out_status == pcfl_pkg::ST_OOM || out_status == pcfl_pkg::ST_REJECT)
                   && out_granted == '0))
    else $error("bad status or nonzero address on failure");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 2'd0)
    else $error("result without an outstanding request");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> pending_r <= 2'd1)
    else $error("request accepted while another is still in work");

endmodule

bind per_cpu_page_free_list pcfl_checker u_pcfl_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_req.valid),
  .in_ready    (in_req.ready),
  .out_valid   (out_rsp.valid),
  .out_ready   (out_rsp.ready),
  .out_status  (out_rsp.status),
  .out_granted (out_rsp.granted_address)
);

// ===== verif/per_cpu_page_free_list_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for per_cpu_page_free_list: directed and random page traffic.
// Predicts each response from its own copy of the lists; uses pcfl_pkg and the channel interfaces.
module per_cpu_page_free_list_tb;

  localparam int CLK_PERIOD = 10;
  localparam int ADDR_W     = pcfl_pkg::ADDR_W;
  localparam int REQ_W      = pcfl_pkg::REQ_W;
  localparam int CFG_DATA_W = pcfl_pkg::CFG_DATA_W;
  localparam int CPU_N      = pcfl_pkg::CPU_COUNT_DEF;
  localparam int PAGE_N     = pcfl_pkg::PAGE_SLOTS_DEF;
  localparam int PAGE_B     = pcfl_pkg::PAGE_BYTES_DEF;
  localparam int STALL_MAX  = 4000;

  typedef struct packed {
    pcfl_pkg::status_t status;
    logic [ADDR_W-1:0] granted;
  } page_result_t;

  logic clk = 1'b0;
  logic rst_n;

  pcfl_req_if req_ch ();
  pcfl_rsp_if rsp_ch ();
  pcfl_cfg_if cfg_ch ();

  per_cpu_page_free_list u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch),
    .cfg_wr  (cfg_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  bit [15:0]         list_top [CPU_N];
  bit                list_top_ok [CPU_N];
  bit [15:0]         next_page [PAGE_N];
  bit                next_page_ok [PAGE_N];
  logic [ADDR_W-1:0] bound_low  = '0;
  logic [ADDR_W-1:0] bound_high = '0;

  page_result_t outcomes_due [$];
  int           mismatches   = 0;
  int           src_idle_pct = 0;
  int           snk_stall_pct = 0;

  function automatic bit pop_page(int c, output bit [15:0] pg);
    pg = '0;
    if (c >= CPU_N || !list_top_ok[c]) return 1'b0;
    if (list_top[c] >= PAGE_N) begin
      list_top_ok[c] = 1'b0;
      return 1'b0;
    end
    pg = list_top[c];
    list_top[c]    = next_page[pg];
    list_top_ok[c] = next_page_ok[pg];
    return 1'b1;
  endfunction

  function automatic page_result_t page_op_outcome(pcfl_pkg::op_t op, logic [REQ_W-1:0] cpu,
                                                   logic [ADDR_W-1:0] addr);
    page_result_t r;
    logic [ADDR_W-1:0] pg;
    bit [15:0] taken;
    bit got;
    r.status  = pcfl_pkg::ST_OK;
    r.granted = '0;
    taken     = '0;
    if (op == pcfl_pkg::OP_FREE) begin
      pg = addr / PAGE_B;
      if ((addr % PAGE_B) != 0 || addr < bound_low || addr >= bound_high ||
          pg >= PAGE_N || int'(cpu) >= CPU_N) begin
        r.status = pcfl_pkg::ST_REJECT;
      end else begin
        next_page[pg]     = list_top[cpu];
        next_page_ok[pg]  = list_top_ok[cpu];
        list_top[cpu]     = pg[15:0];
        list_top_ok[cpu]  = 1'b1;
      end
    end else begin
      got = pop_page(int'(cpu), taken);
      for (int i = 0; i < CPU_N && !got; i++) begin
        if (i != int'(cpu)) got = pop_page(i, taken);
      end
      if (got) r.granted = ADDR_W'(32'(taken) * PAGE_B);
      else r.status = pcfl_pkg::ST_OOM;
    end
    return r;
  endfunction

  task automatic send_req(pcfl_pkg::op_t op, logic [REQ_W-1:0] cpu, logic [ADDR_W-1:0] addr);
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.operation    <= op;
    req_ch.requester    <= cpu;
    req_ch.page_address <= addr;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    outcomes_due.push_back(page_op_outcome(op, cpu, addr));
  endtask

  task automatic wait_quiet();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outcomes_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(pcfl_pkg::cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == pcfl_pkg::REG_LOW_BOUND) bound_low = val;
    else bound_high = val;
    @(posedge clk);
  endtask

  task automatic set_bounds(logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] hi);
    wait_quiet();
    write_reg(pcfl_pkg::REG_LOW_BOUND, lo);
    write_reg(pcfl_pkg::REG_HIGH_BOUND, hi);
  endtask

  task automatic test_reset_state();
    send_req(pcfl_pkg::OP_FREE, 3'd0, 32'h0000_1000);
    send_req(pcfl_pkg::OP_ALLOC, 3'd7, 32'hFFFF_FFFF);
    set_bounds(32'h0000_0000, 32'h0000_0000);
    send_req(pcfl_pkg::OP_FREE, 3'd2, 32'h0000_0000);
  endtask

  task automatic test_bound_extremes();
    set_bounds(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(pcfl_pkg::OP_FREE, 3'd5, 32'hFFFF_F000);
    send_req(pcfl_pkg::OP_FREE, 3'd6, 32'hFFFF_FFFF);
  endtask

  task automatic test_free_checks_and_steal();
    set_bounds(32'h0000_2001, 32'hFFFF_FFFF);
    send_req(pcfl_pkg::OP_FREE, 3'd1, 32'h0000_2000);
    send_req(pcfl_pkg::OP_FREE, 3'd0, 32'h0000_3000);
    send_req(pcfl_pkg::OP_FREE, 3'd0, 32'h0000_3004);
    send_req(pcfl_pkg::OP_FREE, 3'd4, 32'h0800_0000);
    send_req(pcfl_pkg::OP_FREE, 3'd7, 32'h07FF_F000);
    set_bounds(32'h0000_2001, 32'h0000_5000);
    send_req(pcfl_pkg::OP_FREE, 3'd0, 32'h0000_5000);
    send_req(pcfl_pkg::OP_FREE, 3'd0, 32'h0000_4000);
    repeat (4) send_req(pcfl_pkg::OP_ALLOC, 3'd3, 32'h0);
  endtask

  task automatic test_page_zero();
    set_bounds(32'h0000_0000, 32'h0000_1000);
    send_req(pcfl_pkg::OP_FREE, 3'd4, 32'h0000_0000);
    send_req(pcfl_pkg::OP_ALLOC, 3'd4, 32'h0);
    send_req(pcfl_pkg::OP_ALLOC, 3'd4, 32'h0);
  endtask

  task automatic test_double_free();
    set_bounds(32'h0000_0000, 32'h0010_0000);
    send_req(pcfl_pkg::OP_FREE, 3'd1, 32'h0000_9000);
    send_req(pcfl_pkg::OP_FREE, 3'd1, 32'h0000_9000);
    send_req(pcfl_pkg::OP_ALLOC, 3'd1, 32'h0);
    send_req(pcfl_pkg::OP_ALLOC, 3'd1, 32'h0);
    send_req(pcfl_pkg::OP_FREE, 3'd3, 32'h0000_9000);
    send_req(pcfl_pkg::OP_ALLOC, 3'd1, 32'h0);
    send_req(pcfl_pkg::OP_ALLOC, 3'd1, 32'h0);
    send_req(pcfl_pkg::OP_ALLOC, 3'd1, 32'h0);
  endtask

  task automatic test_mixed_traffic(int n, logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] hi,
                                    int idle, int stall);
    longint lo_pg;
    longint hi_pg;
    int span;
    int win;
    int win_base;
    int pick;
    int pg;
    logic [ADDR_W-1:0] addr;
    set_bounds(lo, hi);
    src_idle_pct  = idle;
    snk_stall_pct = stall;
    lo_pg = (longint'(lo) + PAGE_B - 1) / PAGE_B;
    hi_pg = (longint'(hi) + PAGE_B - 1) / PAGE_B;
    if (hi_pg > PAGE_N) hi_pg = PAGE_N;
    span     = (hi_pg > lo_pg) ? int'(hi_pg - lo_pg) : 0;
    win      = (span > 512) ? 512 : span;
    win_base = int'(lo_pg) + ((span > 0) ? $urandom_range(span - win) : 0);
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (span > 0 && $urandom_range(9) == 0) pg = int'(lo_pg) + $urandom_range(span - 1);
      else if (span > 0) pg = win_base + $urandom_range(win - 1);
      else pg = $urandom_range(PAGE_N - 1);
      if (pick < 42) begin
        addr = (span > 0) ? ADDR_W'(pg * PAGE_B) : $urandom();
        send_req(pcfl_pkg::OP_FREE, REQ_W'($urandom_range(CPU_N - 1)), addr);
      end else if (pick < 84) begin
        send_req(pcfl_pkg::OP_ALLOC, REQ_W'($urandom_range(CPU_N - 1)), $urandom());
      end else if (pick < 90) begin
        send_req(pcfl_pkg::op_t'($urandom_range(1)), REQ_W'($urandom_range(7)), $urandom());
      end else if (pick < 95) begin
        addr = ADDR_W'(pg * PAGE_B) | ADDR_W'($urandom_range(PAGE_B - 1, 1));
        send_req(pcfl_pkg::OP_FREE, REQ_W'($urandom_range(7)), addr);
      end else begin
        case ($urandom_range(2))
          0: addr = bound_high & ~ADDR_W'(PAGE_B - 1);
          1: addr = (lo_pg > 0) ? ADDR_W'((lo_pg - 1) * PAGE_B) : 32'h0;
          default: addr = ADDR_W'(PAGE_N * PAGE_B);
        endcase
        send_req(pcfl_pkg::OP_FREE, REQ_W'($urandom_range(7)), addr);
      end
    end
  endtask

  initial begin
    page_result_t exp_res;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
        if (outcomes_due.size() == 0) begin
          $display("%0t: unexpected response, expected none, actual status=%0d addr=%h",
                   $time, rsp_ch.status, rsp_ch.granted_address);
          mismatches++;
        end else begin
          exp_res = outcomes_due.pop_front();
          if (rsp_ch.status !== exp_res.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, exp_res.status, rsp_ch.status);
            mismatches++;
          end
          if (rsp_ch.granted_address !== exp_res.granted) begin
            $display("%0t: granted_address mismatch, expected %h actual %h",
                     $time, exp_res.granted, rsp_ch.granted_address);
            mismatches++;
          end
        end
      end
      rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_MAX) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [ADDR_W-1:0] rand_lo;
    logic [ADDR_W-1:0] rand_hi;
    rst_n               = 1'b0;
    req_ch.valid        = 1'b0;
    req_ch.operation    = pcfl_pkg::OP_FREE;
    req_ch.requester    = '0;
    req_ch.page_address = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = pcfl_pkg::REG_LOW_BOUND;
    cfg_ch.data         = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_bound_extremes();
    test_free_checks_and_steal();
    test_page_zero();
    test_double_free();

    test_mixed_traffic(190, 32'h0000_5123, 32'h0100_0000, 0, 0);
    test_mixed_traffic(190, 32'h0000_0000, 32'hFFFF_FFFF, 48, 0);
    test_mixed_traffic(190, 32'h07FF_0000, 32'h0800_1000, 0, 48);
    rand_lo = $urandom_range(32'h0800_0000);
    rand_hi = rand_lo + $urandom_range(32'h0040_0000);
    test_mixed_traffic(190, rand_lo, rand_hi, 7, 7);

    wait_quiet();
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
